[design/rfcc_pkg.sv]
// Shared types, constants and CRC helpers for the reply frame CRC checker.
`timescale 1ns / 1ps

package rfcc_pkg;

  localparam int MAX_FRAME_DEFAULT = 256;

  localparam logic [7:0] START_BYTE = 8'h28;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;
  localparam logic [3:0] NIB_MASK   = 4'hF;

  // CRC-16 poly 0x1021, one nibble per lookup
  localparam logic [15:0] NIB_TABLE [16] = '{
    16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50A5, 16'h60C6, 16'h70E7,
    16'h8108, 16'h9129, 16'hA14A, 16'hB16B, 16'hC18C, 16'hD1AD, 16'hE1CE, 16'hF1EF
  };

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_START = 3'd1,
    ERR_NO_TERM   = 3'd2,
    ERR_SHORT     = 3'd3,
    ERR_CRC       = 3'd4
  } err_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_buffer;
  } in_item_t;

  typedef struct packed {
    logic       frame_ok;
    logic [2:0] error_kind;
    logic [7:0] payload_length;
  } out_item_t;

  // Frame summary handed from the tracker to the verdict stage
  typedef struct packed {
    logic        short_frame;
    logic        bad_start;
    logic        term_found;
    logic        term_early;
    logic [7:0]  cut_length;
    logic [15:0] crc;
    logic [7:0]  older;
    logic [7:0]  newer;
  } frame_view_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] t;
    t = NIB_TABLE[(c[15:12] ^ b[7:4]) & NIB_MASK] ^ {c[11:0], 4'h0};
    t = NIB_TABLE[(t[15:12] ^ b[3:0]) & NIB_MASK] ^ {t[11:0], 4'h0};
    return t;
  endfunction

  function automatic logic is_reserved(input logic [7:0] v);
    return (v == START_BYTE) || (v == CR_BYTE) || (v == LF_BYTE);
  endfunction

endpackage

[design/reply_frame_crc_checker.sv]
// Top level of the reply frame CRC checker.
`timescale 1ns / 1ps
//
// Bytes of one reply buffer enter on the byte channel, one per transaction,
// with last_in_buffer set on the final byte. Each buffer yields exactly one
// transaction on the result channel: frame_ok, error_kind and payload_length.
// Bytes without the last mark produce nothing.
//
// Throughput is one byte per cycle while byte_ready is high: the frame state
// update (a two-nibble CRC-16 table step) sits between the byte input and
// the state registers. A result is registered in the output or skid slot.
//
// The result side has an output register plus one skid slot, so bytes keep
// flowing while one result waits. byte_ready drops only when both slots
// hold undelivered results. The frame state returns to its start values
// after each last byte.
//
// rst is synchronous and active high; it clears the frame state and both
// result slots. MAX_FRAME bounds the bytes inspected per buffer.
//
module reply_frame_crc_checker #(
  parameter int MAX_FRAME = rfcc_pkg::MAX_FRAME_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  rfcc_pkg::in_item_t  byte_item,
  output logic                result_valid,
  input  logic                result_ready,
  output rfcc_pkg::out_item_t result_item
);
  import rfcc_pkg::*;

  frame_view_t view;
  logic        fire;
  logic        room;

  assign byte_ready = room;
  assign fire       = byte_valid && byte_ready;

  rfcc_frame_track #(
    .MAX_FRAME(MAX_FRAME)
  ) u_track (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (byte_item),
    .view (view)
  );

  rfcc_verdict u_verdict (
    .clk          (clk),
    .rst          (rst),
    .push         (fire && byte_item.last_in_buffer),
    .view         (view),
    .room         (room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule

[design/rfcc_frame_track.sv]
// Per-byte frame state: start check, terminator search, delayed CRC and zero search.
`timescale 1ns / 1ps

module rfcc_frame_track #(
  parameter int MAX_FRAME = rfcc_pkg::MAX_FRAME_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  rfcc_pkg::in_item_t    item,
  output rfcc_pkg::frame_view_t view
);
  import rfcc_pkg::*;

  localparam int PW = $clog2(MAX_FRAME + 1);
  localparam int LW = (PW > 8) ? PW : 8;

  logic [15:0]   running_crc, running_crc_next;
  logic [7:0]    held_older_byte, held_older_byte_next;
  logic [7:0]    held_newer_byte, held_newer_byte_next;
  logic [PW-1:0] byte_position, byte_position_next;
  logic          bad_start_seen, bad_start_seen_next;
  logic          skipping_rest, skipping_rest_next;
  logic          zero_seen, zero_seen_next;
  logic [PW-1:0] zero_position, zero_position_next;
  logic [PW-1:0] term_index, term_index_next;

  logic [PW-1:0] crc_span;
  logic [PW-1:0] cut;
  logic [LW-1:0] cut_wide;

  always_comb begin
    running_crc_next     = running_crc;
    held_older_byte_next = held_older_byte;
    held_newer_byte_next = held_newer_byte;
    byte_position_next   = byte_position;
    bad_start_seen_next  = bad_start_seen;
    skipping_rest_next   = skipping_rest;
    zero_seen_next       = zero_seen;
    zero_position_next   = zero_position;
    term_index_next      = term_index;
    // bytes past the window are ignored entirely
    if (byte_position < PW'(MAX_FRAME)) begin
      if (byte_position == '0 && item.data_byte != START_BYTE) begin
        bad_start_seen_next = 1'b1;
      end
      if (!skipping_rest) begin
        if (item.data_byte == CR_BYTE) begin
          skipping_rest_next = 1'b1;
          term_index_next    = byte_position;
        end else begin
          // CRC trails the input by two bytes
          if (byte_position >= PW'(2)) begin
            running_crc_next = crc_feed(running_crc, held_older_byte);
          end
          held_older_byte_next = held_newer_byte;
          held_newer_byte_next = item.data_byte;
          if (item.data_byte == 8'h00 && !zero_seen) begin
            zero_seen_next     = 1'b1;
            zero_position_next = byte_position;
          end
        end
      end
      byte_position_next = byte_position + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && item.last_in_buffer)) begin
      running_crc     <= '0;
      held_older_byte <= '0;
      held_newer_byte <= '0;
      byte_position   <= '0;
      bad_start_seen  <= 1'b0;
      skipping_rest   <= 1'b0;
      zero_seen       <= 1'b0;
      zero_position   <= '0;
      term_index      <= '0;
    end else if (fire) begin
      running_crc     <= running_crc_next;
      held_older_byte <= held_older_byte_next;
      held_newer_byte <= held_newer_byte_next;
      byte_position   <= byte_position_next;
      bad_start_seen  <= bad_start_seen_next;
      skipping_rest   <= skipping_rest_next;
      zero_seen       <= zero_seen_next;
      zero_position   <= zero_position_next;
      term_index      <= term_index_next;
    end
  end

  // payload length: up to the CRC bytes, cut at the first zero, saturated
  always_comb begin
    crc_span = term_index_next - PW'(2);
    cut      = crc_span;
    if (zero_seen_next && zero_position_next < crc_span) begin
      cut = zero_position_next;
    end
    cut_wide = LW'(cut);
  end

  // CRC and held bytes only matter once the terminator is found, and they
  // do not change on or after the terminator byte
  always_comb begin
    view.short_frame = byte_position_next < PW'(4);
    view.bad_start   = bad_start_seen_next;
    view.term_found  = skipping_rest_next;
    view.term_early  = term_index_next < PW'(4);
    view.cut_length  = (cut_wide > LW'(255)) ? 8'hFF : cut_wide[7:0];
    view.crc         = running_crc;
    view.older       = held_older_byte;
    view.newer       = held_newer_byte;
  end

endmodule

[design/rfcc_verdict.sv]
// Final CRC fix-up and compare, error priority, and the two-slot result register.
`timescale 1ns / 1ps

module rfcc_verdict (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rfcc_pkg::frame_view_t view,
  output logic                  room,
  output logic                  result_valid,
  input  logic                  result_ready,
  output rfcc_pkg::out_item_t   result_item
);
  import rfcc_pkg::*;

  logic [15:0] crc_fixed;
  logic        mismatch;
  err_t        err;
  out_item_t   verdict;
  out_item_t   skid_item;
  logic        skid_valid;
  logic        out_free;

  always_comb begin
    crc_fixed = view.crc;
    // reserved values cannot carry, so a byte-wide bump is exact
    if (is_reserved(crc_fixed[7:0])) begin
      crc_fixed[7:0] = crc_fixed[7:0] + 8'd1;
    end
    if (is_reserved(crc_fixed[15:8])) begin
      crc_fixed[15:8] = crc_fixed[15:8] + 8'd1;
    end
    mismatch = (view.newer != crc_fixed[7:0]) || (view.older != crc_fixed[15:8]);

    priority if (view.short_frame) begin
      err = ERR_SHORT;
    end else if (view.bad_start) begin
      err = ERR_BAD_START;
    end else if (!view.term_found) begin
      err = ERR_NO_TERM;
    end else if (view.term_early) begin
      err = ERR_SHORT;
    end else if (mismatch) begin
      err = ERR_CRC;
    end else begin
      err = ERR_NONE;
    end

    verdict.frame_ok       = (err == ERR_NONE);
    verdict.error_kind     = err;
    verdict.payload_length = (err == ERR_NONE) ? view.cut_length : 8'h00;
  end

  assign out_free = !result_valid || result_ready;
  assign room     = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (push) begin
      // push only happens with the skid slot empty
      if (out_free) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      result_valid <= skid_valid;
      skid_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (out_free) begin
        result_item <= verdict;
      end else begin
        skid_item <= verdict;
      end
    end else if (out_free && skid_valid) begin
      result_item <= skid_item;
    end
  end

endmodule

[design/rfcc_checker.sv]
// Port-level checks on the reply frame CRC checker, bound to its top level.
`timescale 1ns / 1ps

module rfcc_checker (
  input logic                clk,
  input logic                rst,
  input logic                byte_valid,
  input logic                byte_ready,
  input rfcc_pkg::in_item_t  byte_item,
  input logic                result_valid,
  input logic                result_ready,
  input rfcc_pkg::out_item_t result_item
);
  import rfcc_pkg::*;

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_item))
    else $error("stalled result changed or dropped");

  // no result without a last byte
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !result_valid && !(byte_valid && byte_ready && byte_item.last_in_buffer)
    |=> !result_valid)
    else $error("result appeared without a last byte");

  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_item.frame_ok == (result_item.error_kind == ERR_NONE))
                     && (result_item.error_kind <= ERR_CRC))
    else $error("frame_ok and error_kind disagree");

  a_fail_len: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.frame_ok |-> result_item.payload_length == 8'h00)
    else $error("failed frame carries a payload length");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind reply_frame_crc_checker rfcc_checker u_rfcc_checker (.*);

[tb/reply_frame_crc_checker_test.sv]
// Self-checking testbench for the reply frame CRC checker: directed table, then random buffers.
`timescale 1ns / 1ps

module reply_frame_crc_checker_test;
  import rfcc_pkg::*;

  localparam int MAX_FRAME   = MAX_FRAME_DEFAULT;
  localparam int ITEM_TARGET = 1900;
  localparam int LONG_HOLD   = 80;
  localparam int SETTLE      = 8;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [7:0]  FILL_BYTE = 8'h55;
  localparam int unsigned NO_NUL    = 32'hFFFF_FFFF;

  localparam logic [1:0] STEER_NONE = 2'd0;
  localparam logic [1:0] STEER_BUMP = 2'd1;
  localparam logic [1:0] STEER_ZERO = 2'd2;

  typedef logic [7:0] octet_t;

  typedef struct packed {
    logic [47:0] lead;    // leading bytes, first byte in the top octet
    logic [3:0]  n_lead;
    logic [8:0]  fill;    // filler bytes after the lead
    logic        sealed;  // append CRC bytes and CR
    logic [1:0]  tail;    // junk bytes after CR
    logic [1:0]  steer;   // tune the last body byte for a CRC corner
    logic        typed;   // verdict given below instead of predicted
    out_item_t   want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [17] = '{
    '{48'h28_00_00_00_00_00, 4'd1, 9'd0,   1'b0, 2'd0, STEER_NONE, 1'b1,
      '{1'b0, ERR_SHORT, 8'd0}},
    '{48'hFF_00_00_00_00_00, 4'd2, 9'd0,   1'b0, 2'd0, STEER_NONE, 1'b1,
      '{1'b0, ERR_SHORT, 8'd0}},
    '{48'h28_41_0D_00_00_00, 4'd3, 9'd0,   1'b0, 2'd0, STEER_NONE, 1'b1,
      '{1'b0, ERR_SHORT, 8'd0}},
    '{48'h00_41_42_43_0D_00, 4'd5, 9'd0,   1'b0, 2'd0, STEER_NONE, 1'b1,
      '{1'b0, ERR_BAD_START, 8'd0}},
    '{48'hFF_00_00_00_00_00, 4'd1, 9'd0,   1'b1, 2'd0, STEER_NONE, 1'b1,
      '{1'b0, ERR_BAD_START, 8'd0}},
    '{48'h28_41_42_43_44_00, 4'd5, 9'd0,   1'b0, 2'd0, STEER_NONE, 1'b1,
      '{1'b0, ERR_NO_TERM, 8'd0}},
    '{48'h28_41_42_0D_45_00, 4'd5, 9'd0,   1'b0, 2'd0, STEER_NONE, 1'b1,
      '{1'b0, ERR_SHORT, 8'd0}},
    '{48'h28_FF_FF_FF_0D_00, 4'd5, 9'd0,   1'b0, 2'd0, STEER_NONE, 1'b0,
      '{1'b0, ERR_NONE, 8'd0}},
    '{48'h28_41_00_00_00_00, 4'd2, 9'd0,   1'b1, 2'd0, STEER_NONE, 1'b0,
      '{1'b0, ERR_NONE, 8'd0}},
    '{48'h28_41_00_42_00_00, 4'd4, 9'd0,   1'b1, 2'd0, STEER_NONE, 1'b0,
      '{1'b0, ERR_NONE, 8'd0}},
    '{48'h28_51_52_00_00_00, 4'd3, 9'd0,   1'b1, 2'd0, STEER_ZERO, 1'b0,
      '{1'b0, ERR_NONE, 8'd0}},
    '{48'h28_61_62_00_00_00, 4'd3, 9'd0,   1'b1, 2'd0, STEER_BUMP, 1'b0,
      '{1'b0, ERR_NONE, 8'd0}},
    '{48'h28_41_42_00_00_00, 4'd3, 9'd0,   1'b1, 2'd3, STEER_NONE, 1'b0,
      '{1'b0, ERR_NONE, 8'd0}},
    '{48'h28_FF_00_80_7F_00, 4'd5, 9'd0,   1'b1, 2'd0, STEER_NONE, 1'b0,
      '{1'b0, ERR_NONE, 8'd0}},
    '{48'h28_00_00_00_00_00, 4'd1, 9'd252, 1'b1, 2'd0, STEER_NONE, 1'b0,
      '{1'b0, ERR_NONE, 8'd0}},
    '{48'h28_00_00_00_00_00, 4'd1, 9'd254, 1'b1, 2'd0, STEER_NONE, 1'b1,
      '{1'b0, ERR_NO_TERM, 8'd0}},
    '{48'h28_00_00_00_00_00, 4'd1, 9'd300, 1'b0, 2'd0, STEER_NONE, 1'b1,
      '{1'b0, ERR_NO_TERM, 8'd0}}
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_ready;
  in_item_t  byte_item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result_item;

  reply_frame_crc_checker #(.MAX_FRAME(MAX_FRAME)) dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_item   (byte_item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_item (result_item)
  );

  always #4 clk = ~clk;

  // Frame tracker state, mirrors the block
  logic [15:0] crc_acc;
  octet_t      crc_older;
  octet_t      crc_newer;
  int unsigned bytes_in_frame;
  bit          opened_wrong;
  bit          cr_seen;
  int unsigned cr_index;
  int unsigned first_nul;

  out_item_t verdicts_due [$];
  octet_t    frame_buf [$];

  int  bytes_sent;
  int  buffers_sent;
  int  results_checked;
  int  frames_passed;
  int  bumped_frames;
  int  misfits;
  bit  tx_bursty;
  int  burst_left;
  bit  holdoff_req;
  int  hold_left;
  int  rx_mode;
  int  rx_cycle;
  out_item_t want;

  function automatic logic [15:0] crc16_step(logic [15:0] c, octet_t b);
    logic [15:0] r;
    int i;
    r = c ^ {b, 8'h00};
    for (i = 0; i < 8; i++)
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  function automatic bit is_framing(octet_t v);
    return v == START_BYTE || v == CR_BYTE || v == LF_BYTE;
  endfunction

  // Raise CRC bytes that would collide with framing characters
  function automatic logic [15:0] seal_crc(logic [15:0] raw);
    logic [15:0] c;
    c = raw;
    if (is_framing(c[7:0])) c = c + 16'h0001;
    if (is_framing(c[15:8])) c = c + 16'h0100;
    return c;
  endfunction

  function automatic void clear_frame();
    crc_acc = '0;
    crc_older = '0;
    crc_newer = '0;
    bytes_in_frame = 0;
    opened_wrong = 0;
    cr_seen = 0;
    cr_index = 0;
    first_nul = NO_NUL;
  endfunction

  // Advance the tracker by one byte; return 1 with the verdict on a last byte
  function automatic bit judge_byte(input in_item_t it, output out_item_t verdict);
    err_t        err;
    int unsigned pay;
    logic [15:0] sealed;
    octet_t      b;
    err = ERR_NONE;
    pay = 0;
    verdict = '0;
    b = it.data_byte;
    if (bytes_in_frame < MAX_FRAME) begin
      if (bytes_in_frame == 0 && b != START_BYTE) opened_wrong = 1;
      if (!cr_seen) begin
        if (b == CR_BYTE) begin
          cr_seen = 1;
          cr_index = bytes_in_frame;
        end else begin
          // CRC bytes trail by two, so feed the older held byte
          if (bytes_in_frame >= 2) crc_acc = crc16_step(crc_acc, crc_older);
          crc_older = crc_newer;
          crc_newer = b;
          if (b == 8'h00 && first_nul == NO_NUL) first_nul = bytes_in_frame;
        end
      end
      bytes_in_frame++;
    end
    if (!it.last_in_buffer) return 0;
    if (bytes_in_frame < 4) err = ERR_SHORT;
    else if (opened_wrong) err = ERR_BAD_START;
    else if (!cr_seen) err = ERR_NO_TERM;
    else if (cr_index < 4) err = ERR_SHORT;
    else begin
      sealed = seal_crc(crc_acc);
      if (crc_older != sealed[15:8] || crc_newer != sealed[7:0]) err = ERR_CRC;
      else begin
        pay = cr_index - 2;
        if (first_nul < pay) pay = first_nul;
        if (pay > 255) pay = 255;
      end
    end
    verdict.frame_ok = (err == ERR_NONE);
    verdict.error_kind = err;
    verdict.payload_length = pay[7:0];
    clear_frame();
    return 1;
  endfunction

  function automatic logic [15:0] frame_buf_crc();
    logic [15:0] c;
    c = '0;
    foreach (frame_buf[i]) c = crc16_step(c, frame_buf[i]);
    return c;
  endfunction

  // Tune the last body byte so the CRC lands on a framing value or a zero byte
  function automatic void steer_last(logic [1:0] steer);
    logic [15:0] raw;
    logic [15:0] sealed;
    int v;
    for (v = 0; v < 256; v++) begin
      if (v[7:0] == CR_BYTE) continue;
      frame_buf[frame_buf.size() - 1] = v[7:0];
      raw = frame_buf_crc();
      sealed = seal_crc(raw);
      if (steer == STEER_BUMP && raw != sealed) break;
      if (steer == STEER_ZERO && (sealed[15:8] == 8'h00 || sealed[7:0] == 8'h00)) break;
    end
  endfunction

  function automatic void seal_frame();
    logic [15:0] raw;
    logic [15:0] c;
    raw = frame_buf_crc();
    c = seal_crc(raw);
    if (c != raw) bumped_frames++;
    frame_buf.push_back(c[15:8]);
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(CR_BYTE);
  endfunction

  function automatic octet_t any_but_cr();
    octet_t v;
    v = octet_t'($urandom_range(0, 255));
    if (v == CR_BYTE) v = octet_t'($urandom_range(0, 12));
    return v;
  endfunction

  // Well-formed frame with random content
  function automatic void make_good(int len);
    int k;
    frame_buf.delete();
    frame_buf.push_back(START_BYTE);
    for (k = 0; k < len; k++) frame_buf.push_back(any_but_cr());
    if ($urandom_range(0, 9) == 0) frame_buf[$urandom_range(1, len)] = 8'h00;
    case ($urandom_range(0, 19))
      0, 1, 2: steer_last(STEER_BUMP);
      3:       steer_last(STEER_ZERO);
      default: ;
    endcase
    seal_frame();
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) frame_buf.push_back(octet_t'($urandom_range(0, 255)));
  endfunction

  // Offer one byte, hold it until accepted, then record what it should cause
  task automatic push_byte(in_item_t it, bit typed, out_item_t typed_want);
    out_item_t verdict;
    if (tx_bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        byte_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      burst_left--;
    end
    byte_valid <= 1'b1;
    byte_item <= it;
    do @(posedge clk); while (!byte_ready);
    bytes_sent++;
    if (judge_byte(it, verdict)) verdicts_due.push_back(typed ? typed_want : verdict);
  endtask

  task automatic send_frame(bit typed, out_item_t typed_want);
    in_item_t it;
    foreach (frame_buf[i]) begin
      it.data_byte = frame_buf[i];
      it.last_in_buffer = (i == frame_buf.size() - 1);
      push_byte(it, typed, typed_want);
    end
    buffers_sent++;
  endtask

  task automatic drain_results();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  // Result side: stall patterns that change every so often, plus one long hold-off
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 3);
    if (rst) result_ready <= 1'b0;
    else if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (holdoff_req) begin
      holdoff_req = 0;
      hold_left = LONG_HOLD;
      result_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: result_ready <= 1'b1;
        1: result_ready <= ($urandom_range(0, 1) == 1);
        2: result_ready <= (rx_cycle % 4 == 0);
        default: result_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (verdicts_due.size() == 0) begin
        misfits++;
        if (misfits <= 10)
          $display("result with nothing pending: ok=%0b err=%0d len=%0d",
                   result_item.frame_ok, result_item.error_kind,
                   result_item.payload_length);
      end else begin
        want = verdicts_due.pop_front();
        results_checked++;
        frames_passed += result_item.frame_ok;
        if (result_item.frame_ok !== want.frame_ok ||
            result_item.error_kind !== want.error_kind ||
            result_item.payload_length !== want.payload_length) begin
          misfits++;
          if (misfits <= 10)
            $display("result %0d mismatch: expected ok=%0b err=%0d len=%0d, got ok=%0b err=%0d len=%0d",
                     results_checked, want.frame_ok, want.error_kind, want.payload_length,
                     result_item.frame_ok, result_item.error_kind,
                     result_item.payload_length);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[reply_frame_crc_checker] ERROR");
    $finish;
  end

  initial begin
    dir_row_t row;
    int k;
    int r;
    int goal;
    bit did_holdoff;
    bit did_pause;
    octet_t flip;
    clear_frame();
    tx_bursty = 1;
    did_holdoff = 0;
    did_pause = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      row = DIR_ROWS[i];
      frame_buf.delete();
      for (k = 0; k < row.n_lead; k++) frame_buf.push_back(row.lead[47 - 8 * k -: 8]);
      repeat (row.fill) frame_buf.push_back(FILL_BYTE);
      if (row.steer != STEER_NONE) steer_last(row.steer);
      if (row.sealed) seal_frame();
      for (k = 0; k < row.tail; k++) frame_buf.push_back(k[0] ? CR_BYTE : 8'h00);
      send_frame(row.typed, row.want);
    end

    goal = ITEM_TARGET;
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 19) == 0) tx_bursty = !tx_bursty;
      if (!did_holdoff && bytes_sent > goal - ITEM_TARGET / 2 - 400) begin
        // Stall results while short frames keep coming, so the block fills up
        did_holdoff = 1;
        holdoff_req = 1;
        tx_bursty = 0;
        repeat (40) begin
          make_good(1);
          send_frame(0, '0);
        end
        tx_bursty = 1;
      end
      if (!did_pause && bytes_sent > goal - ITEM_TARGET / 3) begin
        did_pause = 1;
        drain_results();
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        make_good(($urandom_range(0, 49) == 0) ? $urandom_range(20, 250) : $urandom_range(1, 12));
      end else if (r < 70) begin
        make_good($urandom_range(1, 12));
        k = $urandom_range(0, 1);
        flip = octet_t'(1) << $urandom_range(0, 7);
        // corrupt one of the two CRC bytes just before the CR
        foreach (frame_buf[i])
          if (frame_buf[i] == CR_BYTE && i >= 2) begin
            frame_buf[i - 1 - k] = frame_buf[i - 1 - k] ^ flip;
            break;
          end
      end else if (r < 80) begin
        frame_buf.delete();
        repeat ($urandom_range(1, 10)) frame_buf.push_back(octet_t'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1) frame_buf[0] = START_BYTE;
      end else if (r < 87) begin
        make_good($urandom_range(1, 12));
        frame_buf[0] = octet_t'($urandom_range(0, 255));
        if (frame_buf[0] == START_BYTE) frame_buf[0] = 8'h29;
      end else if (r < 93) begin
        frame_buf.delete();
        frame_buf.push_back(START_BYTE);
        repeat ($urandom_range(3, 12)) frame_buf.push_back(any_but_cr());
      end else begin
        frame_buf.delete();
        frame_buf.push_back(START_BYTE);
        repeat ($urandom_range(0, 2)) frame_buf.push_back(any_but_cr());
        frame_buf.push_back(CR_BYTE);
        repeat ($urandom_range(0, 2)) frame_buf.push_back(octet_t'($urandom_range(0, 255)));
      end
      send_frame(0, '0);
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    $display("sent %0d bytes in %0d buffers; checked %0d results, %0d frames passed",
             bytes_sent, buffers_sent, results_checked, frames_passed);
    $display("%0d frames carried a raised CRC byte, %0d mismatches", bumped_frames, misfits);
    if (misfits == 0 && verdicts_due.size() == 0) $display("[reply_frame_crc_checker] OK");
    else $display("[reply_frame_crc_checker] ERROR");
    $finish;
  end

endmodule

[files.f]
design/rfcc_pkg.sv
design/rfcc_frame_track.sv
design/rfcc_verdict.sv
design/reply_frame_crc_checker.sv
design/rfcc_checker.sv
tb/reply_frame_crc_checker_test.sv
